[rtl/core/tsr_pkg.sv]
package tsr_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEF = 10;

   localparam int COLOR_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // products in the row setup: a column term and a row term for each edge
   localparam int MUL_STEPS = 6;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_VERTEX_A_X = 3'd0,
      REG_VERTEX_A_Y = 3'd1,
      REG_VERTEX_B_X = 3'd2,
      REG_VERTEX_B_Y = 3'd3,
      REG_VERTEX_C_X = 3'd4,
      REG_VERTEX_C_Y = 3'd5,
      REG_FILL_COLOR = 3'd6
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SCAN,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic valid;
      logic found;
   } span_status_type;

endpackage

[rtl/core/tsr_mul.sv]
module tsr_mul #(
   parameter int W = tsr_pkg::COORD_BITS_DEF + 1
) (
   input  logic                  clock,
   input  logic signed [W-1:0]   op_a,
   input  logic signed [W-1:0]   op_b,
   output logic signed [2*W-1:0] prod
);

   logic signed [2*W-1:0] prod_ff;
   logic signed [2*W-1:0] prod_in;

   assign prod_in = (2*W)'(op_a) * (2*W)'(op_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[rtl/core/tsr_ctrl.sv]
module tsr_ctrl #(
   parameter int COORD_BITS = tsr_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic signed [COORD_BITS-1:0] cx,
   input  logic signed [COORD_BITS-1:0] cy,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] row_y,
   input  logic                         out_free,
   output logic                         idle,
   output tsr_pkg::span_status_type     status,
   output logic signed [COORD_BITS-1:0] span_row,
   output logic signed [COORD_BITS-1:0] span_start_x,
   output logic        [COORD_BITS:0]   span_width
);

   localparam int D = COORD_BITS + 1;
   localparam int P = 2 * D;
   localparam int E = P + 1;

   tsr_pkg::ctrl_state_type state_ff, state_in;

   logic [2:0]                  cnt_ff, cnt_in;
   logic signed [COORD_BITS-1:0] y_ff, y_in;
   logic signed [COORD_BITS-1:0] x_ff, x_in;
   logic signed [COORD_BITS-1:0] left_ff, left_in;
   logic signed [COORD_BITS-1:0] right_ff, right_in;
   logic                        found_ff, found_in;
   logic signed [E-1:0]         e_ff [3];
   logic signed [E-1:0]         e_in [3];

   logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [D-1:0]          dy [3];
   logic signed [COORD_BITS-1:0] ux, uy, wx, wy;
   logic [1:0]                   sel;
   logic [2:0]                   cm1;
   logic [1:0]                   cap;
   logic signed [D-1:0]          op_a, op_b;
   logic signed [P-1:0]          prod;
   logic                         col_hit;
   logic [D-1:0]                 diff;

   // bounding box
   always_comb begin
      lo_x = ax;
      if (bx < lo_x) lo_x = bx;
      if (cx < lo_x) lo_x = cx;
      hi_x = ax;
      if (bx > hi_x) hi_x = bx;
      if (cx > hi_x) hi_x = cx;
      lo_y = ay;
      if (by < lo_y) lo_y = by;
      if (cy < lo_y) lo_y = cy;
      hi_y = ay;
      if (by > hi_y) hi_y = by;
      if (cy > hi_y) hi_y = cy;
   end

   // column step of each edge function, added as the scan moves along the row
   assign dy[0] = D'(ay) - D'(by);
   assign dy[1] = D'(by) - D'(cy);
   assign dy[2] = D'(cy) - D'(ay);

   // operand select for the shared multiplier
   assign sel = cnt_ff[2:1];

   always_comb begin
      case (sel)
         2'd0: begin
            ux = ax; uy = ay; wx = bx; wy = by;
         end
         2'd1: begin
            ux = bx; uy = by; wx = cx; wy = cy;
         end
         default: begin
            ux = cx; uy = cy; wx = ax; wy = ay;
         end
      endcase
      if (!cnt_ff[0]) begin
         op_a = D'(lo_x) - D'(wx);
         op_b = D'(uy) - D'(wy);
      end else begin
         op_a = D'(ux) - D'(wx);
         op_b = D'(y_ff) - D'(wy);
      end
   end

   tsr_mul #(.W(D)) u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign cm1 = cnt_ff - 3'd1;
   assign cap = cm1[2:1];

   assign col_hit = (e_ff[0][E-1] == e_ff[1][E-1]) && (e_ff[1][E-1] == e_ff[2][E-1]);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      y_in     = y_ff;
      x_in     = x_ff;
      left_in  = left_ff;
      right_in = right_ff;
      found_in = found_ff;
      e_in     = e_ff;
      unique case (state_ff)
         tsr_pkg::ST_IDLE: begin
            if (start) begin
               y_in     = row_y;
               found_in = 1'b0;
               cnt_in   = 3'd0;
               if (row_y >= lo_y && row_y <= hi_y) begin
                  state_in = tsr_pkg::ST_MUL;
               end else begin
                  state_in = tsr_pkg::ST_DONE;
               end
            end
         end
         tsr_pkg::ST_MUL: begin
            // product of the previous step lands now
            if (cnt_ff != 3'd0) begin
               if (!cm1[0]) begin
                  e_in[cap] = E'(prod);
               end else begin
                  e_in[cap] = e_ff[cap] - E'(prod);
               end
            end
            if (cnt_ff == 3'(tsr_pkg::MUL_STEPS)) begin
               x_in     = lo_x;
               state_in = tsr_pkg::ST_SCAN;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         tsr_pkg::ST_SCAN: begin
            if (col_hit) begin
               if (!found_ff) left_in = x_ff;
               right_in = x_ff;
               found_in = 1'b1;
            end
            if (x_ff == hi_x) begin
               state_in = tsr_pkg::ST_DONE;
            end else begin
               x_in = x_ff + COORD_BITS'(1);
               for (int k = 0; k < 3; k++) begin
                  e_in[k] = e_ff[k] + E'(dy[k]);
               end
            end
         end
         tsr_pkg::ST_DONE: begin
            if (out_free) state_in = tsr_pkg::ST_IDLE;
         end
         default: state_in = tsr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsr_pkg::ST_IDLE;
         found_ff <= 1'b0;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
         cnt_ff   <= cnt_in;
      end
      y_ff     <= y_in;
      x_ff     <= x_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      e_ff     <= e_in;
   end

   assign diff = D'(right_ff) - D'(left_ff) + D'(1);

   assign idle         = (state_ff == tsr_pkg::ST_IDLE);
   assign status.valid = (state_ff == tsr_pkg::ST_DONE);
   assign status.found = found_ff;
   assign span_row     = y_ff;
   assign span_start_x = found_ff ? left_ff : '0;
   assign span_width   = found_ff ? diff : '0;

endmodule

[rtl/core/triangle_span_rasterizer.sv]
// triangle span rasterizer, edge-function test per column
//
// csr channel: csr_valid/csr_ready with csr_index and csr_wdata; index 0..5 are the
//   vertex coordinates a.x a.y b.x b.y c.x c.y, index 6 is the fill color, other
//   indexes are dropped. csr_ready is always high; write only while the block is idle
// req channel: one beat names one row (row_y in req_tdata)
// rsp channel: one beat per request; tuser carries span_found, tdata carries row,
//   leftmost inside column, span width and color
// sequence: the row check is made as the beat is taken, then setup through the
//   shared multiplier (two products per edge), a scan over the bounding-box
//   columns and a load into the output register; a row outside the bounding box
//   goes straight to the output register load
// throughput: one row at a time, req_tready is high only between rows, so a new
//   row is taken only once the last one has left the scan and its result has
//   moved to the output register; the setup, the bounding-box scan and any stall at the output register set the rate
// reset: vertex and color registers clear to zero, no beat pending, ready for a row
//   at once
// stall: the result waits in the output register; the next row is taken and
//   scanned meanwhile, and its result holds inside until the register frees up
module triangle_span_rasterizer #(
   parameter int COORD_BITS = tsr_pkg::COORD_BITS_DEF,
   localparam int REQ_DATA_BITS = ((COORD_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((3 * COORD_BITS + 1 + tsr_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // config writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tsr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tsr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   // row requests
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_DATA_BITS-1:0]           req_tdata,  // row_y
   // span results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_DATA_BITS-1:0]           rsp_tdata,  // span_row, span_start_x,
                                                          // span_width, span_color
   output logic                               rsp_tuser   // span_found
);

   // vertex and color registers
   logic signed [COORD_BITS-1:0]      ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [tsr_pkg::COLOR_BITS-1:0]    color_ff;
   logic signed [COORD_BITS-1:0]      coord_wr;

   // output register
   logic                              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0]          rsp_tdata_ff, rsp_tdata_in;
   logic                              rsp_tuser_ff, rsp_tuser_in;

   logic                              idle;
   logic                              out_free;
   logic                              load;
   tsr_pkg::span_status_type          status;
   logic signed [COORD_BITS-1:0]      span_row, span_start_x;
   logic [COORD_BITS:0]               span_width;

   assign csr_ready = 1'b1;
   assign coord_wr  = csr_wdata[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff    <= '0;
         ay_ff    <= '0;
         bx_ff    <= '0;
         by_ff    <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         color_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tsr_pkg::REG_VERTEX_A_X: ax_ff    <= coord_wr;
            tsr_pkg::REG_VERTEX_A_Y: ay_ff    <= coord_wr;
            tsr_pkg::REG_VERTEX_B_X: bx_ff    <= coord_wr;
            tsr_pkg::REG_VERTEX_B_Y: by_ff    <= coord_wr;
            tsr_pkg::REG_VERTEX_C_X: cx_ff    <= coord_wr;
            tsr_pkg::REG_VERTEX_C_Y: cy_ff    <= coord_wr;
            tsr_pkg::REG_FILL_COLOR: color_ff <= csr_wdata[tsr_pkg::COLOR_BITS-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   assign req_tready = idle;

   tsr_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .ax           (ax_ff),
      .ay           (ay_ff),
      .bx           (bx_ff),
      .by           (by_ff),
      .cx           (cx_ff),
      .cy           (cy_ff),
      .start        (req_tvalid && req_tready),
      .row_y        (req_tdata[COORD_BITS-1:0]),
      .out_free     (out_free),
      .idle         (idle),
      .status       (status),
      .span_row     (span_row),
      .span_start_x (span_start_x),
      .span_width   (span_width)
   );

   // output register frees up when empty or when its beat is taken this cycle
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign load     = status.valid && out_free;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tuser_in  = status.found;
         rsp_tdata_in  = RSP_DATA_BITS'({color_ff, span_width, span_start_x, span_row});
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

[rtl/core/tsr_checker.sv]
module tsr_checker #(
   parameter int COORD_BITS = tsr_pkg::COORD_BITS_DEF,
   localparam int RSP_DATA_BITS = ((3 * COORD_BITS + 1 + tsr_pkg::COLOR_BITS + 7) / 8) * 8,
   localparam int START_LSB = COORD_BITS,
   localparam int WIDTH_LSB = 2 * COORD_BITS
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [RSP_DATA_BITS-1:0]           rsp_tdata,
   input logic                               rsp_tuser
);

   logic [COORD_BITS-1:0] start_f;
   logic [COORD_BITS:0]   width_f;

   assign start_f = rsp_tdata[START_LSB +: COORD_BITS];
   assign width_f = rsp_tdata[WIDTH_LSB +: (COORD_BITS + 1)];

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // a row keeps the block busy, so a second row is not taken right behind it
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken on back-to-back cycles");

   a_empty_span: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> start_f == '0 && width_f == '0)
      else $error("empty span with nonzero start or width");

   a_found_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> width_f != '0)
      else $error("found span with zero width");

endmodule

bind triangle_span_rasterizer tsr_checker #(.COORD_BITS(COORD_BITS)) u_tsr_checker (.*);

[test/span_checker.sv]
`timescale 1ns / 100ps

// watches the three channels, predicts each span and compares it with the result beat
module span_checker (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   csr_valid,
   input  logic                                                   csr_ready,
   input  logic [tsr_pkg::CSR_INDEX_BITS-1:0]                     csr_index,
   input  logic [tsr_pkg::CSR_DATA_BITS-1:0]                      csr_wdata,
   input  logic                                                   req_tvalid,
   input  logic                                                   req_tready,
   input  logic [((tsr_pkg::COORD_BITS_DEF + 7) / 8) * 8 - 1:0]   req_tdata,  // row_y
   input  logic                                                   rsp_tvalid,
   input  logic                                                   rsp_tready,
   // span_row, span_start_x, span_width, span_color
   input  logic [((3 * tsr_pkg::COORD_BITS_DEF + 1 + tsr_pkg::COLOR_BITS + 7) / 8) * 8 - 1:0]
                                                                  rsp_tdata,
   input  logic                                                   rsp_tuser,  // span_found
   output int                                                     errors,
   output int                                                     pending
);

   localparam int C          = tsr_pkg::COORD_BITS_DEF;
   localparam int COLOR_BITS = tsr_pkg::COLOR_BITS;

   typedef struct {
      int found;
      int row;
      int start_x;
      int width;
      int color;
   } span_type;

   int       vtx_x[3];
   int       vtx_y[3];
   int       fill;
   span_type spans_due[$];

   function automatic bit edge_below(int px, int py, int ux, int uy, int wx, int wy);
      return ((px - wx) * (uy - wy) - (ux - wx) * (py - wy)) < 0;
   endfunction

   function automatic span_type trace_row(int y);
      span_type sp;
      int       lo_x;
      int       hi_x;
      int       lo_y;
      int       hi_y;
      bit       s1;
      bit       s2;
      bit       s3;
      lo_x = vtx_x[0];
      hi_x = vtx_x[0];
      lo_y = vtx_y[0];
      hi_y = vtx_y[0];
      for (int i = 1; i < 3; i++) begin
         if (vtx_x[i] < lo_x) lo_x = vtx_x[i];
         if (vtx_x[i] > hi_x) hi_x = vtx_x[i];
         if (vtx_y[i] < lo_y) lo_y = vtx_y[i];
         if (vtx_y[i] > hi_y) hi_y = vtx_y[i];
      end
      sp.found   = 0;
      sp.row     = y;
      sp.start_x = 0;
      sp.width   = 0;
      sp.color   = fill;
      if (y >= lo_y && y <= hi_y) begin
         for (int x = lo_x; x <= hi_x; x++) begin
            s1 = edge_below(x, y, vtx_x[0], vtx_y[0], vtx_x[1], vtx_y[1]);
            s2 = edge_below(x, y, vtx_x[1], vtx_y[1], vtx_x[2], vtx_y[2]);
            s3 = edge_below(x, y, vtx_x[2], vtx_y[2], vtx_x[0], vtx_y[0]);
            if (s1 == s2 && s2 == s3) begin
               if (!sp.found) sp.start_x = x;
               sp.width = x - sp.start_x + 1;
               sp.found = 1;
            end
         end
      end
      return sp;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_beats
      span_type want;
      if (reset) begin
         vtx_x = '{0, 0, 0};
         vtx_y = '{0, 0, 0};
         fill  = 0;
         spans_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tsr_pkg::REG_VERTEX_A_X: vtx_x[0] = int'($signed(csr_wdata[C-1:0]));
               tsr_pkg::REG_VERTEX_A_Y: vtx_y[0] = int'($signed(csr_wdata[C-1:0]));
               tsr_pkg::REG_VERTEX_B_X: vtx_x[1] = int'($signed(csr_wdata[C-1:0]));
               tsr_pkg::REG_VERTEX_B_Y: vtx_y[1] = int'($signed(csr_wdata[C-1:0]));
               tsr_pkg::REG_VERTEX_C_X: vtx_x[2] = int'($signed(csr_wdata[C-1:0]));
               tsr_pkg::REG_VERTEX_C_Y: vtx_y[2] = int'($signed(csr_wdata[C-1:0]));
               tsr_pkg::REG_FILL_COLOR: fill = int'(csr_wdata[COLOR_BITS-1:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (spans_due.size() == 0) begin
               errors++;
               $display("%0t: span beat with nothing expected, actual row %0d", $time,
                        $signed(rsp_tdata[C-1:0]));
            end else begin
               want = spans_due.pop_front();
               check_field("span_found", want.found, int'(rsp_tuser));
               check_field("span_row", want.row, int'($signed(rsp_tdata[C-1:0])));
               check_field("span_start_x", want.start_x,
                           int'($signed(rsp_tdata[2*C-1:C])));
               check_field("span_width", want.width, int'(rsp_tdata[3*C:2*C]));
               check_field("span_color", want.color,
                           int'(rsp_tdata[3*C+COLOR_BITS:3*C+1]));
            end
         end
         if (req_tvalid && req_tready)
            spans_due.push_back(trace_row(int'($signed(req_tdata[C-1:0]))));
      end
      pending = spans_due.size();
   end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int COORD_BITS     = tsr_pkg::COORD_BITS_DEF;
   localparam int COLOR_BITS     = tsr_pkg::COLOR_BITS;
   localparam int CSR_INDEX_BITS = tsr_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS  = tsr_pkg::CSR_DATA_BITS;
   localparam int REQ_DATA_BITS  = ((COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((3 * COORD_BITS + 1 + COLOR_BITS + 7) / 8) * 8;

   localparam int ROW_COUNT    = 1170;
   // a full-width row scans every grid column plus setup; allow many times that with no beat
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 1100;

   // index past the register list, writes to it must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;  // row_y
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;        // span_row, span_start_x, span_width, span_color
   logic                      rsp_tuser;        // span_found

   int errors;
   int pending;
   int rows_sent;
   int idle_cycles;
   int bb_lo_y;
   int bb_hi_y;
   int stall_mode;
   int stall_left;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   triangle_span_rasterizer uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   span_checker span_check (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .errors     (errors),
      .pending    (pending)
   );

   // result side back-pressure: modes of random length
   // always ready, coin flip, mostly stalled, rare stall
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 5) == 0);
         default: rsp_tready <= ($urandom_range(0, 15) != 0);
      endcase
   end

   // watchdog: any beat on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_tvalid && req_tready) ||
          (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int clamp_coord(int v);
      if (v < -512) return -512;
      if (v > 511) return 511;
      return v;
   endfunction

   // coordinate word with junk in the bits above the field
   function automatic logic [CSR_DATA_BITS-1:0] coord_word(int v);
      logic [CSR_DATA_BITS-1:0] w;
      w = CSR_DATA_BITS'($urandom_range(0, 65535));
      w[COORD_BITS-1:0] = v[COORD_BITS-1:0];
      return w;
   endfunction

   function automatic int near(int center, int spread);
      return clamp_coord(center + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // anywhere on the grid, often right at the edges
   function automatic int pick_wide();
      case ($urandom_range(0, 5))
         0: return -512;
         1: return 511;
         default: return int'($urandom_range(0, 1023)) - 512;
      endcase
   endfunction

   // mostly rows in or just around the bounding box, some anywhere
   function automatic int pick_row();
      if ($urandom_range(0, 6) != 0)
         return clamp_coord(bb_lo_y - 2 + int'($urandom_range(0, bb_hi_y - bb_lo_y + 4)));
      return int'($urandom_range(0, 1023)) - 512;
   endfunction

   // leaves csr_valid high so writes can go back to back
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // wait for the block to drain, then load a new triangle and color
   task automatic program_triangle(int ax, int ay, int bx, int by, int cx, int cy,
                                   int color, bit stray);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      write_reg(tsr_pkg::REG_VERTEX_A_X, coord_word(ax));
      write_reg(tsr_pkg::REG_VERTEX_A_Y, coord_word(ay));
      write_reg(tsr_pkg::REG_VERTEX_B_X, coord_word(bx));
      write_reg(tsr_pkg::REG_VERTEX_B_Y, coord_word(by));
      write_reg(tsr_pkg::REG_VERTEX_C_X, coord_word(cx));
      write_reg(tsr_pkg::REG_VERTEX_C_Y, coord_word(cy));
      write_reg(tsr_pkg::REG_FILL_COLOR, color[CSR_DATA_BITS-1:0]);
      if (stray) write_reg(REG_UNUSED, CSR_DATA_BITS'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
      // vertical extent, used only to aim the row stimulus
      bb_lo_y = ay;
      bb_hi_y = ay;
      if (by < bb_lo_y) bb_lo_y = by;
      if (cy < bb_lo_y) bb_lo_y = cy;
      if (by > bb_hi_y) bb_hi_y = by;
      if (cy > bb_hi_y) bb_hi_y = cy;
   endtask

   // one row beat; tvalid stays high for a following beat in the same burst
   task automatic send_row(int row);
      logic [REQ_DATA_BITS-1:0] word;
      word = REQ_DATA_BITS'($urandom_range(0, 65535));
      word[COORD_BITS-1:0] = row[COORD_BITS-1:0];
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      rows_sent++;
   endtask

   initial begin
      int ax;
      int ay;
      int bx;
      int by;
      int cx;
      int cy;
      int cen_x;
      int cen_y;
      int spread;
      int nrows;
      int burst;
      bit big_tri;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset registers: all vertices at the origin, a single inside point
      bb_lo_y = 0;
      bb_hi_y = 0;
      send_row(0);
      send_row(1);
      send_row(-512);
      send_row(511);

      // triangle spanning the whole grid, widest possible span on the bottom edge
      program_triangle(-512, -512, 511, -512, -512, 511, 16'hFFFF, 1'b0);
      send_row(-512);
      send_row(0);
      send_row(511);

      // small triangle, stray write past the register list, black fill
      program_triangle(-3, -4, 6, -4, 1, 7, 16'h0000, 1'b1);
      send_row(-5);
      send_row(-4);
      send_row(0);
      send_row(7);
      send_row(8);

      // collinear vertices
      program_triangle(0, 0, 10, 10, 20, 20, 16'hF800, 1'b0);
      send_row(0);
      send_row(5);
      send_row(20);

      // sliver with rows in the box but no column inside
      program_triangle(0, 0, 9, 10, 10, 11, 16'h07E0, 1'b0);
      send_row(1);
      send_row(5);
      send_row(11);

      // same small triangle wound the other way
      program_triangle(-3, -4, 1, 7, 6, -4, 16'h001F, 1'b1);
      send_row(0);
      send_row(3);

      // random phases: mostly small triangles, a few spanning the grid
      while (rows_sent < ROW_COUNT) begin
         big_tri = ($urandom_range(0, 7) == 0);
         if (big_tri) begin
            ax = pick_wide();
            ay = pick_wide();
            bx = pick_wide();
            by = pick_wide();
            cx = pick_wide();
            cy = pick_wide();
            nrows = $urandom_range(3, 8);
         end else begin
            cen_x  = int'($urandom_range(0, 980)) - 490;
            cen_y  = int'($urandom_range(0, 980)) - 490;
            spread = $urandom_range(0, 24);
            ax = near(cen_x, spread);
            ay = near(cen_y, spread);
            bx = near(cen_x, spread);
            by = near(cen_y, spread);
            cx = near(cen_x, spread);
            cy = near(cen_y, spread);
            nrows = $urandom_range(8, 40);
         end
         program_triangle(ax, ay, bx, by, cx, cy, $urandom_range(0, 65535),
                          $urandom_range(0, 3) == 0);
         // bursts of rows with random gaps, sometimes none
         while (nrows > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && nrows > 0) begin
               send_row(pick_row());
               burst--;
               nrows--;
            end
            if ($urandom_range(0, 2) != 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(negedge clock);
            end
         end
      end

      // drain, then give a stray beat time to show up
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/core/tsr_pkg.sv
rtl/core/tsr_mul.sv
rtl/core/tsr_ctrl.sv
rtl/core/triangle_span_rasterizer.sv
rtl/core/tsr_checker.sv
test/span_checker.sv
test/tb.sv
